/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* design/tcbl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbl_pkg
// Constants and types shared by the two-choice bin loader.
// ----------------------------------------------------------------------------
package tcbl_pkg;

	localparam int BINS       = 1024;
	localparam int LOAD_WIDTH = 16;
	localparam int BIN_W      = $clog2(BINS);
	localparam int EPOCH_W    = 4;

	// fixed widths of the channel fields
	localparam int FIELD_BIN_W  = 10;
	localparam int FIELD_LOAD_W = 16;
	localparam int CFG_DATA_W   = 11;

	typedef logic [BIN_W-1:0]      bin_addr_t;
	typedef logic [LOAD_WIDTH-1:0] load_t;
	typedef logic [EPOCH_W-1:0]    epoch_t;

	localparam load_t LOAD_TOP = '1;

	// register indexes
	typedef enum logic {
		CFG_BIN_COUNT  = 1'b0,
		CFG_TWO_CHOICE = 1'b1
	} cfg_index_t;

	// request codes
	typedef enum logic {
		REQ_THROW = 1'b0,
		REQ_CLEAR = 1'b1
	} req_type_t;

	typedef struct packed {
		epoch_t tag;
		load_t  load;
	} mem_word_t;

endpackage

/* design/tcbl_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbl_req_if
// Request channel: throw or clear words with two candidate bins.
// ----------------------------------------------------------------------------
interface tcbl_req_if;
	logic                              valid;
	logic                              ready;
	logic                              req_type;
	logic [tcbl_pkg::FIELD_BIN_W-1:0]  first_bin;
	logic [tcbl_pkg::FIELD_BIN_W-1:0]  second_bin;

	modport source (output valid, req_type, first_bin, second_bin, input ready);
	modport sink   (input valid, req_type, first_bin, second_bin, output ready);
endinterface

/* design/tcbl_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbl_res_if
// Result channel: chosen bin, its load, running maximum and error flag.
// ----------------------------------------------------------------------------
interface tcbl_res_if;
	logic                              valid;
	logic                              ready;
	logic [tcbl_pkg::FIELD_BIN_W-1:0]  chosen_bin;
	logic [tcbl_pkg::FIELD_LOAD_W-1:0] chosen_load;
	logic [tcbl_pkg::FIELD_LOAD_W-1:0] max_load;
	logic                              index_error;

	modport source (output valid, chosen_bin, chosen_load, max_load, index_error,
		input ready);
	modport sink   (input valid, chosen_bin, chosen_load, max_load, index_error,
		output ready);
endinterface

/* design/two_choice_bin_loader.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_choice_bin_loader
// Balls-into-bins loader with power-of-two-choices placement.
// ----------------------------------------------------------------------------
// Usage:
//  req : throw words carry two candidate bins, clear words empty all bins.
//  res : one word per request: chosen bin, new load, peak load, error flag.
//  cfg : cfg_we/cfg_index/cfg_data write bin_count and two_choice_mode;
//        write only while the block is idle.
// Throughput: one request per cycle outside stalls and rewrites. Loads live
//  in a 1024 x 20 bit RAM with two registered read ports and one write port;
//  a one-entry bypass covers the previous word's write racing the next read.
// Pipeline: the accepted request's RAM read lands in the compare stage, then
//  compare/increment fills the output register, held there until res.ready.
// Clear: bumps a 4-bit epoch tag held with each load; every 16th clear
//  wraps the tag and starts a rewrite of all 1024 entries; req.ready stays
//  low from that clear's compare cycle to the end of the rewrite.
// Reset: a rewrite of all 1024 entries runs after arst_n is released,
//  req.ready low throughout; the config port is live.
// Stall: a held result parks in the output register; one further word may
//  sit in the compare stage, after which req.ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_choice_bin_loader (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [tcbl_pkg::CFG_DATA_W-1:0]     cfg_data,
	tcbl_req_if.sink                            req,
	tcbl_res_if.source                          res
);

	// configuration
	logic [tcbl_pkg::CFG_DATA_W-1:0] bin_count_q;
	logic                            two_choice_q;

	// load RAM
	tcbl_pkg::mem_word_t mem [tcbl_pkg::BINS];
	logic                mem_we;
	tcbl_pkg::bin_addr_t mem_wa;
	tcbl_pkg::mem_word_t mem_wd;
	tcbl_pkg::mem_word_t rd_a_s1, rd_b_s1;

	// compare stage
	logic                              valid_s1;
	logic                              req_s1;
	logic [tcbl_pkg::FIELD_BIN_W-1:0]  a_s1, b_s1;

	// bypass of the last write
	logic                fwd_en_q;
	tcbl_pkg::bin_addr_t fwd_addr_q;
	tcbl_pkg::load_t     fwd_load_q;

	tcbl_pkg::epoch_t    epoch_q;
	tcbl_pkg::load_t     peak_q;
	logic                sweep_q;
	tcbl_pkg::bin_addr_t sweep_cnt_q;

	// output register
	logic                              out_valid_q;
	logic [tcbl_pkg::FIELD_BIN_W-1:0]  out_bin_q;
	logic [tcbl_pkg::FIELD_LOAD_W-1:0] out_load_q;
	logic [tcbl_pkg::FIELD_LOAD_W-1:0] out_max_q;
	logic                              out_err_q;

	logic acc, s1_fire, clear_s1, wrap_s1, err_s1, place_s1;
	logic a_ok, b_ok, hit_a, hit_b, pick_a;
	logic [tcbl_pkg::FIELD_BIN_W-1:0] pick_bin;
	tcbl_pkg::load_t la, lb, lp, new_load, new_peak;

	// ---------------- handshake ----------------
	assign clear_s1 = (req_s1 == tcbl_pkg::REQ_CLEAR);
	assign wrap_s1  = valid_s1 && clear_s1 && (&epoch_q);
	assign s1_fire  = valid_s1 && (!out_valid_q || res.ready);
	assign req.ready = !sweep_q && (!valid_s1 || s1_fire) && !wrap_s1;
	assign acc      = req.valid && req.ready;

	// ---------------- compare / increment ----------------
	always_comb begin
		a_ok = ({1'b0, a_s1} < bin_count_q) && (32'(a_s1) < tcbl_pkg::BINS);
		b_ok = ({1'b0, b_s1} < bin_count_q) && (32'(b_s1) < tcbl_pkg::BINS);
		err_s1 = !a_ok || (two_choice_q && !b_ok);
		hit_a = fwd_en_q && (fwd_addr_q == tcbl_pkg::bin_addr_t'(a_s1));
		hit_b = fwd_en_q && (fwd_addr_q == tcbl_pkg::bin_addr_t'(b_s1));
		// a stale epoch tag reads as an empty bin
		la = hit_a ? fwd_load_q : ((rd_a_s1.tag == epoch_q) ? rd_a_s1.load : '0);
		lb = hit_b ? fwd_load_q : ((rd_b_s1.tag == epoch_q) ? rd_b_s1.load : '0);
		// ties go to the second bin
		pick_a   = !two_choice_q || (la < lb);
		pick_bin = pick_a ? a_s1 : b_s1;
		lp       = pick_a ? la : lb;
		new_load = (lp == tcbl_pkg::LOAD_TOP) ? lp : lp + tcbl_pkg::load_t'(1);
		new_peak = (new_load > peak_q) ? new_load : peak_q;
		place_s1 = s1_fire && !clear_s1 && !err_s1;
	end

	// RAM write mux: the rewrite pass owns the port while it runs
	always_comb begin
		if (sweep_q) begin
			mem_we = 1'b1;
			mem_wa = sweep_cnt_q;
			mem_wd = '{tag: epoch_q, load: '0};
		end else begin
			mem_we = place_s1;
			mem_wa = tcbl_pkg::bin_addr_t'(pick_bin);
			mem_wd = '{tag: epoch_q, load: new_load};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (acc) begin
			rd_a_s1 <= mem[tcbl_pkg::bin_addr_t'(req.first_bin)];
			rd_b_s1 <= mem[tcbl_pkg::bin_addr_t'(req.second_bin)];
		end
	end

	// ---------------- config ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q  <= tcbl_pkg::CFG_DATA_W'(1024);
			two_choice_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				tcbl_pkg::CFG_BIN_COUNT:  bin_count_q  <= cfg_data;
				tcbl_pkg::CFG_TWO_CHOICE: two_choice_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------- control state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_en_q    <= 1'b0;
			epoch_q     <= '0;
			peak_q      <= '0;
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end

			if (sweep_q) begin
				sweep_cnt_q <= sweep_cnt_q + tcbl_pkg::bin_addr_t'(1);
				if (sweep_cnt_q == tcbl_pkg::bin_addr_t'(tcbl_pkg::BINS - 1)) begin
					sweep_q <= 1'b0;
				end
			end

			if (s1_fire && clear_s1) begin
				epoch_q  <= epoch_q + tcbl_pkg::epoch_t'(1);
				peak_q   <= '0;
				fwd_en_q <= 1'b0;
				if (&epoch_q) begin
					sweep_q     <= 1'b1;
					sweep_cnt_q <= '0;
				end
			end else if (place_s1) begin
				peak_q   <= new_peak;
				fwd_en_q <= 1'b1;
			end

			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1 <= req.req_type;
			a_s1   <= req.first_bin;
			b_s1   <= req.second_bin;
		end
		if (place_s1) begin
			fwd_addr_q <= tcbl_pkg::bin_addr_t'(pick_bin);
			fwd_load_q <= new_load;
		end
		if (s1_fire) begin
			if (clear_s1) begin
				out_bin_q  <= '0;
				out_load_q <= '0;
				out_max_q  <= '0;
				out_err_q  <= 1'b0;
			end else if (err_s1) begin
				out_bin_q  <= '0;
				out_load_q <= '0;
				out_max_q  <= tcbl_pkg::FIELD_LOAD_W'(peak_q);
				out_err_q  <= 1'b1;
			end else begin
				out_bin_q  <= pick_bin;
				out_load_q <= tcbl_pkg::FIELD_LOAD_W'(new_load);
				out_max_q  <= tcbl_pkg::FIELD_LOAD_W'(new_peak);
				out_err_q  <= 1'b0;
			end
		end
	end

	assign res.valid       = out_valid_q;
	assign res.chosen_bin  = out_bin_q;
	assign res.chosen_load = out_load_q;
	assign res.max_load    = out_max_q;
	assign res.index_error = out_err_q;

	// ---------------- assertions ----------------
	`ASSERT_ALWAYS(a_sweep_pipe_empty, clk, arst_n, !(sweep_q && valid_s1))
	`ASSERT_NEXT(a_clear_drops_bypass, clk, arst_n, s1_fire && clear_s1, !fwd_en_q)
	`ASSERT_NEXT(a_peak_covers_load, clk, arst_n, place_s1, peak_q >= $past(new_load))
	`ASSERT_ALWAYS(a_err_no_load, clk, arst_n,
		!(out_valid_q && out_err_q) || (out_load_q == '0 && out_bin_q == '0))

endmodule
